@@ rtl/tbrf_pkg.sv @@
`timescale 1ns / 1ps
// tbrf_pkg: shared constants for the timestamped byte ring fifo
// command and status codes, field widths and parameter defaults
// no dependencies

package tbrf_pkg;

  // parameter defaults
  localparam int DEPTH_DEF    = 4096;
  localparam int MAX_PULL_DEF = 64;

  // payload field widths
  localparam int CMD_W  = 2;
  localparam int BYTE_W = 8;
  localparam int TS_W   = 32;
  localparam int LEN_W  = 7;
  localparam int STAT_W = 3;
  localparam int FILL_W = 13;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PULL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_END  = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_ACCEPTED = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_ENDED    = 3'd2;
  localparam logic [STAT_W-1:0] ST_DATA     = 3'd3;
  localparam logic [STAT_W-1:0] ST_WAIT     = 3'd4;

endpackage

@@ rtl/tbrf_if.sv @@
`timescale 1ns / 1ps
// tbrf_if: valid/ready channel interfaces for commands and results
// depends on tbrf_pkg for field widths

// command channel
interface tbrf_in_if;
  logic                         valid;
  logic                         ready;
  logic [tbrf_pkg::CMD_W-1:0]   command;
  logic [tbrf_pkg::BYTE_W-1:0]  data_byte;
  logic [tbrf_pkg::TS_W-1:0]    timestamp;
  logic [tbrf_pkg::LEN_W-1:0]   pull_length;

  modport source (output valid, command, data_byte, timestamp, pull_length,
                  input ready);
  modport sink   (input valid, command, data_byte, timestamp, pull_length,
                  output ready);
endinterface

// result channel
interface tbrf_out_if;
  logic                         valid;
  logic                         ready;
  logic [tbrf_pkg::STAT_W-1:0]  status;
  logic [tbrf_pkg::BYTE_W-1:0]  out_byte;
  logic                         is_fill;
  logic [tbrf_pkg::TS_W-1:0]    presentation_time;
  logic [tbrf_pkg::FILL_W-1:0]  fill_level;
  logic                         ended;
  logic                         last;

  modport source (output valid, status, out_byte, is_fill, presentation_time,
                  fill_level, ended, last, input ready);
  modport sink   (input valid, status, out_byte, is_fill, presentation_time,
                  fill_level, ended, last, output ready);
endinterface

@@ rtl/tbrf_mem.sv @@
`timescale 1ns / 1ps
// tbrf_mem: byte and timestamp ring storage, one write and one read port
// registered read data; depends on tbrf_pkg for field widths

module tbrf_mem #(
  parameter int DEPTH = tbrf_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [tbrf_pkg::BYTE_W-1:0] wbyte,
  input  logic [tbrf_pkg::TS_W-1:0]   wtime,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [tbrf_pkg::BYTE_W-1:0] rbyte,
  output logic [tbrf_pkg::TS_W-1:0]   rtime
);

  logic [tbrf_pkg::BYTE_W-1:0] byte_mem [DEPTH];
  logic [tbrf_pkg::TS_W-1:0]   time_mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      byte_mem[waddr] <= wbyte;
      time_mem[waddr] <= wtime;
    end
  end

  // read port, data held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rbyte <= byte_mem[raddr];
      rtime <= time_mem[raddr];
    end
  end

endmodule

@@ rtl/tbrf_ptr_unit.sv @@
`timescale 1ns / 1ps
// tbrf_ptr_unit: shared ring pointer incrementer with wrap at DEPTH
// serves the write pointer on pushes and the read pointer while streaming
// depends on tbrf_pkg for the default depth

module tbrf_ptr_unit #(
  parameter int DEPTH = tbrf_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic [AW-1:0] ptr,
  output logic [AW-1:0] ptr_adv
);

  // increment and wrap to zero past the last entry
  always_comb begin
    if (ptr == AW'(DEPTH - 1)) begin
      ptr_adv = '0;
    end else begin
      ptr_adv = ptr + AW'(1);
    end
  end

endmodule

@@ rtl/timestamped_byte_ring_fifo_core.sv @@
`timescale 1ns / 1ps
// timestamped_byte_ring_fifo_core: ring fifo of bytes with timestamps
// push, end, wait: result loads via S_ONE; no new command is taken until it is loaded
// pull of n bytes: first byte via the memory read register and the output register, then
//   one per cycle while results are not stalled, paced by the single memory read port
// reset: pointers, fill count, end flag and presentation time clear; memories do not
// depends on tbrf_pkg, tbrf_if, tbrf_mem, tbrf_ptr_unit

module timestamped_byte_ring_fifo_core #(
  parameter int DEPTH    = tbrf_pkg::DEPTH_DEF,
  parameter int MAX_PULL = tbrf_pkg::MAX_PULL_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tbrf_in_if.sink    in_ch,
  tbrf_out_if.source out_ch
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > tbrf_pkg::LEN_W) ? CW : tbrf_pkg::LEN_W;
  localparam int LW   = tbrf_pkg::LEN_W;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ONE  = 2'd1;
  localparam logic [1:0] S_STRM = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          end_r, end_nxt;
  logic [tbrf_pkg::TS_W-1:0] time_r, time_nxt;
  logic [LW-1:0] rem_r, rem_nxt;
  logic [LW-1:0] avail_r, avail_nxt;
  logic          first_r, first_nxt;
  logic [tbrf_pkg::STAT_W-1:0] res_r, res_nxt;

  // output register
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_load;
  logic [tbrf_pkg::STAT_W-1:0]   o_status;
  logic [tbrf_pkg::BYTE_W-1:0]   o_byte;
  logic                          o_fill;
  logic [tbrf_pkg::TS_W-1:0]     o_time;
  logic                          o_last;
  logic [tbrf_pkg::STAT_W-1:0]   out_status_r;
  logic [tbrf_pkg::BYTE_W-1:0]   out_byte_r;
  logic                          out_fill_r;
  logic [tbrf_pkg::TS_W-1:0]     out_time_r;
  logic [tbrf_pkg::FILL_W-1:0]   out_level_r;
  logic                          out_ended_r;
  logic                          out_last_r;

  // shared pointer unit and memory hookup
  logic [AW-1:0] ptr_op, ptr_adv;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr;
  logic [tbrf_pkg::BYTE_W-1:0] mem_byte;
  logic [tbrf_pkg::TS_W-1:0]   mem_time;

  logic          in_acc, out_free, full, short_pull;
  logic [LW-1:0] len_c, avail_c;
  logic [CMPW-1:0] cnt_cmp, len_cmp;
  logic [CW+tbrf_pkg::FILL_W-1:0] cnt_wide;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && (state_r == S_IDLE);
  assign out_free    = !out_valid_r || out_ch.ready;
  assign full        = (cnt_r == CW'(DEPTH));

  // pull length clamped to 1..MAX_PULL
  always_comb begin
    if (in_ch.pull_length == '0) begin
      len_c = LW'(1);
    end else if (in_ch.pull_length > LW'(MAX_PULL)) begin
      len_c = LW'(MAX_PULL);
    end else begin
      len_c = in_ch.pull_length;
    end
  end

  // compare held bytes against the request
  assign cnt_cmp    = CMPW'(cnt_r);
  assign len_cmp    = CMPW'(len_c);
  assign short_pull = (cnt_cmp < len_cmp);
  assign avail_c    = short_pull ? cnt_cmp[LW-1:0] : len_c;
  assign cnt_wide   = {{tbrf_pkg::FILL_W{1'b0}}, cnt_r};

  assign ptr_op  = (state_r == S_IDLE) ? wr_ptr_r : rd_ptr_r;
  assign rd_addr = (state_r == S_IDLE) ? rd_ptr_r : ptr_adv;
  assign wr_en   = in_acc && (in_ch.command == tbrf_pkg::CMD_PUSH) && !end_r && !full;

  tbrf_ptr_unit #(.DEPTH(DEPTH), .AW(AW)) u_ptr (
    .ptr     (ptr_op),
    .ptr_adv (ptr_adv)
  );

  tbrf_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_ptr_r),
    .wbyte (in_ch.data_byte),
    .wtime (in_ch.timestamp),
    .re    (rd_en),
    .raddr (rd_addr),
    .rbyte (mem_byte),
    .rtime (mem_time)
  );

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    end_nxt    = end_r;
    time_nxt   = time_r;
    rem_nxt    = rem_r;
    avail_nxt  = avail_r;
    first_nxt  = first_r;
    res_nxt    = res_r;
    rd_en      = 1'b0;
    out_load   = 1'b0;
    o_status   = res_r;
    o_byte     = '0;
    o_fill     = 1'b0;
    o_time     = time_r;
    o_last     = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          case (in_ch.command)
            tbrf_pkg::CMD_PUSH: begin
              state_nxt = S_ONE;
              if (end_r) begin
                res_nxt = tbrf_pkg::ST_ENDED;
              end else if (full) begin
                res_nxt = tbrf_pkg::ST_FULL;
              end else begin
                res_nxt    = tbrf_pkg::ST_ACCEPTED;
                wr_ptr_nxt = ptr_adv;
                cnt_nxt    = cnt_r + CW'(1);
              end
            end
            tbrf_pkg::CMD_PULL: begin
              if (short_pull && !end_r) begin
                res_nxt   = tbrf_pkg::ST_WAIT;
                state_nxt = S_ONE;
              end else begin
                cnt_nxt   = cnt_r - CW'(avail_c);
                rem_nxt   = len_c;
                avail_nxt = avail_c;
                first_nxt = 1'b1;
                rd_en     = (avail_c != '0);
                state_nxt = S_STRM;
              end
            end
            tbrf_pkg::CMD_END: begin
              end_nxt   = 1'b1;
              res_nxt   = tbrf_pkg::ST_ACCEPTED;
              state_nxt = S_ONE;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_ONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_STRM: begin
        if (out_free) begin
          out_load = 1'b1;
          o_status = tbrf_pkg::ST_DATA;
          o_last   = (rem_r == LW'(1));
          rem_nxt  = rem_r - LW'(1);
          if (avail_r != '0) begin
            // stored byte; the first one sets the presentation time
            o_byte = mem_byte;
            if (first_r) begin
              o_time   = mem_time;
              time_nxt = mem_time;
            end
            first_nxt  = 1'b0;
            rd_ptr_nxt = ptr_adv;
            avail_nxt  = avail_r - LW'(1);
            rd_en      = (avail_r > LW'(1));
          end else begin
            // zero fill after end of stream
            o_fill = 1'b1;
          end
          if (rem_r == LW'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output valid tracking
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      cnt_r       <= '0;
      end_r       <= 1'b0;
      time_r      <= '0;
      rem_r       <= '0;
      avail_r     <= '0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      cnt_r       <= cnt_nxt;
      end_r       <= end_nxt;
      time_r      <= time_nxt;
      rem_r       <= rem_nxt;
      avail_r     <= avail_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (out_load) begin
      out_status_r <= o_status;
      out_byte_r   <= o_byte;
      out_fill_r   <= o_fill;
      out_time_r   <= o_time;
      out_level_r  <= cnt_wide[tbrf_pkg::FILL_W-1:0];
      out_ended_r  <= end_r;
      out_last_r   <= o_last;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.status            = out_status_r;
  assign out_ch.out_byte          = out_byte_r;
  assign out_ch.is_fill           = out_fill_r;
  assign out_ch.presentation_time = out_time_r;
  assign out_ch.fill_level        = out_level_r;
  assign out_ch.ended             = out_ended_r;
  assign out_ch.last              = out_last_r;

endmodule
